// ===== hw/rtl/command_history_ring_assert.svh =====
// Assertion macros used by the command history ring sequencer (chr_ctrl).
`ifndef COMMAND_HISTORY_RING_ASSERT_SVH
`define COMMAND_HISTORY_RING_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define CHR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("command history ring check failed");
// Next-cycle implication, checked out of reset.
`define CHR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("command history ring check failed");
`else
`define CHR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CHR_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/chr_pkg.sv =====
// Shared types, codes and defaults of the command history ring.
`timescale 1ns / 1ps

package chr_pkg;

    localparam int ENTRIES_DEFAULT     = 16;
    localparam int ENTRY_CHARS_DEFAULT = 32;

    // operation codes
    localparam logic [2:0] OP_INSERT   = 3'd0;
    localparam logic [2:0] OP_UP       = 3'd1;
    localparam logic [2:0] OP_DOWN     = 3'd2;
    localparam logic [2:0] OP_HOME     = 3'd3;
    localparam logic [2:0] OP_READ_CUR = 3'd4;
    localparam logic [2:0] OP_READ_AGE = 3'd5;
    localparam logic [2:0] OP_CLEAR    = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_in;
        logic       last_char;
        logic [3:0] entry_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] char_out;
        logic       char_valid;
        logic       last_result;
        logic [3:0] stored_count;
        logic [3:0] cursor_position;
    } t_out_item;

endpackage

// ===== hw/rtl/chr_mem.sv =====
// Character store: one write port, two registered read ports.
`timescale 1ns / 1ps

module chr_mem #(
    parameter int ENTRIES     = 16,
    parameter int ENTRY_CHARS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [$clog2(ENTRIES*ENTRY_CHARS)-1:0]  i_wr_addr,
    input  logic [7:0]                              i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [$clog2(ENTRIES*ENTRY_CHARS)-1:0]  i_rd_addr0,
    input  logic [$clog2(ENTRIES*ENTRY_CHARS)-1:0]  i_rd_addr1,
    output logic [7:0]                              o_rd_data0,
    output logic [7:0]                              o_rd_data1
);

    localparam int DEPTH = ENTRIES * ENTRY_CHARS;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd0;
    logic [7:0] r_rd1;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd0 <= r_mem[i_rd_addr0];
            r_rd1 <= r_mem[i_rd_addr1];
        end
    end

    assign o_rd_data0 = r_rd0;
    assign o_rd_data1 = r_rd1;

endmodule

// ===== hw/rtl/chr_obuf.sv =====
// Two-entry output queue between the sequencer and the result channel.
`timescale 1ns / 1ps

module chr_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  chr_pkg::t_out_item i_push_item,
    output logic              o_space,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output chr_pkg::t_out_item o_out_item
);

    import chr_pkg::*;

    logic [1:0] r_fill;
    logic [1:0] n_fill;
    t_out_item  r_head;
    t_out_item  n_head;
    t_out_item  r_tail;
    t_out_item  n_tail;
    logic       pop;

    assign pop = (r_fill != 2'd0) && !i_out_stall;

    always_comb begin
        n_fill = r_fill;
        n_head = r_head;
        n_tail = r_tail;
        case ({i_push, pop})
            2'b10: begin
                if (r_fill == 2'd0) begin
                    n_head = i_push_item;
                end else begin
                    n_tail = i_push_item;
                end
                n_fill = r_fill + 2'd1;
            end
            2'b01: begin
                n_head = r_tail;
                n_fill = r_fill - 2'd1;
            end
            2'b11: begin
                if (r_fill == 2'd1) begin
                    n_head = i_push_item;
                end else begin
                    n_head = r_tail;
                    n_tail = i_push_item;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
    end

    assign o_space     = (r_fill != 2'd2);
    assign o_out_valid = (r_fill != 2'd0);
    assign o_out_item  = r_head;

endmodule

// ===== hw/rtl/chr_ctrl.sv =====
// Sequencer: ring pointers, browse cursor, insert checks and read streaming.
`timescale 1ns / 1ps
`include "command_history_ring_assert.svh"

module chr_ctrl #(
    parameter int ENTRIES     = 16,
    parameter int ENTRY_CHARS = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    input  chr_pkg::t_in_item                       i_item,
    output logic                                    o_in_stall,
    output logic                                    o_push,
    output chr_pkg::t_out_item                      o_push_item,
    input  logic                                    i_space,
    output logic                                    o_wr_en,
    output logic [$clog2(ENTRIES*ENTRY_CHARS)-1:0]  o_wr_addr,
    output logic [7:0]                              o_wr_data,
    output logic                                    o_rd_en,
    output logic [$clog2(ENTRIES*ENTRY_CHARS)-1:0]  o_rd_addr0,
    output logic [$clog2(ENTRIES*ENTRY_CHARS)-1:0]  o_rd_addr1,
    input  logic [7:0]                              i_rd_data0,
    input  logic [7:0]                              i_rd_data1
);

    import chr_pkg::*;

    localparam int SW  = $clog2(ENTRIES);
    localparam int SW1 = SW + 1;
    localparam int CW  = $clog2(ENTRY_CHARS);
    localparam int AW  = $clog2(ENTRIES * ENTRY_CHARS);
    localparam int AW1 = AW + 1;
    localparam int XW  = ((SW > 4) ? SW : 4) + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(ENTRIES - 1);
    localparam logic [CW-1:0] MAX_LEN   = CW'(ENTRY_CHARS - 1);
    localparam logic [CW-1:0] LEN_LIM   = CW'(ENTRY_CHARS - 2);

    typedef enum logic [2:0] {S_IDLE, S_INS, S_TERM, S_RESP, S_RD} t_state;

    t_state          r_state,     n_state;
    logic [SW-1:0]   r_oldest,    n_oldest;
    logic [SW-1:0]   r_next,      n_next;
    logic [SW-1:0]   r_cursor,    n_cursor;
    logic [CW-1:0]   r_ins_len,   n_ins_len;
    logic            r_differs,   n_differs;
    logic            r_too_long,  n_too_long;
    logic [7:0]      r_char,      n_char;
    logic            r_last,      n_last;
    logic [SW-1:0]   r_slot,      n_slot;
    logic [CW-1:0]   r_k,         n_k;
    logic [1:0]      r_status,    n_status;
    logic [AW-1:0]   r_term_addr, n_term_addr;

    logic [SW-1:0]   held_cnt;
    logic [SW-1:0]   newest;
    logic [XW-1:0]   age_full;
    logic            age_go;
    logic [CW-1:0]   new_len;
    logic            dif;
    logic            too_long;
    logic [7:0]      tail_char;
    logic [7:0]      next_char;

    function automatic logic [AW-1:0] addr_of(input logic [SW-1:0] slot,
                                              input logic [CW-1:0] idx);
        logic [AW1-1:0] a;
        a = AW1'(slot) * AW1'(ENTRY_CHARS) + AW1'(idx);
        return AW'(a);
    endfunction

    // index of the look-ahead character, kept inside the slot
    function automatic logic [CW-1:0] idx_after(input logic [CW-1:0] i);
        return (i >= LEN_LIM) ? i : i + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SW-1:0] slot_prev(input logic [SW-1:0] s);
        return (s == '0) ? LAST_SLOT : s - 1'b1;
    endfunction

    function automatic logic [SW-1:0] age_slot(input logic [SW-1:0] nxt,
                                               input logic [SW-1:0] age);
        logic [SW1-1:0] t;
        t = SW1'(nxt) + SW1'(ENTRIES) - SW1'(1) - SW1'(age);
        if (t >= SW1'(ENTRIES)) begin
            t = t - SW1'(ENTRIES);
        end
        return SW'(t);
    endfunction

    always_comb begin
        if (r_next >= r_oldest) begin
            held_cnt = r_next - r_oldest;
        end else begin
            held_cnt = SW'(SW1'(r_next) + SW1'(ENTRIES) - SW1'(r_oldest));
        end
    end

    assign newest     = slot_prev(r_next);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_next      = r_next;
        n_cursor    = r_cursor;
        n_ins_len   = r_ins_len;
        n_differs   = r_differs;
        n_too_long  = r_too_long;
        n_char      = r_char;
        n_last      = r_last;
        n_slot      = r_slot;
        n_k         = r_k;
        n_status    = r_status;
        n_term_addr = r_term_addr;

        o_wr_en     = 1'b0;
        o_wr_addr   = r_term_addr;
        o_wr_data   = 8'd0;
        o_rd_en     = 1'b0;
        o_rd_addr0  = '0;
        o_rd_addr1  = '0;
        o_push      = 1'b0;
        o_push_item = '{status: r_status, char_out: 8'd0, char_valid: 1'b0,
                        last_result: 1'b1, stored_count: 4'(held_cnt),
                        cursor_position: 4'(r_cursor)};

        age_full  = '0;
        age_go    = 1'b0;
        new_len   = r_ins_len;
        dif       = r_differs;
        too_long  = r_too_long;
        tail_char = 8'd0;
        next_char = 8'd0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_char   = i_item.char_in;
                    n_last   = i_item.last_char;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                    unique case (i_item.operation)
                        OP_INSERT: begin
                            // fetch the newest entry at this and the next position
                            o_rd_en    = 1'b1;
                            o_rd_addr0 = addr_of(newest, r_ins_len);
                            o_rd_addr1 = addr_of(newest, idx_after(r_ins_len));
                            n_state    = S_INS;
                        end
                        OP_UP: begin
                            if (r_cursor < held_cnt) begin
                                n_cursor = r_cursor + 1'b1;
                            end else begin
                                n_status = ST_FAIL;
                            end
                        end
                        OP_DOWN: begin
                            if (r_cursor != '0) begin
                                n_cursor = r_cursor - 1'b1;
                            end else begin
                                n_status = ST_FAIL;
                            end
                        end
                        OP_HOME: begin
                            n_cursor = '0;
                        end
                        OP_READ_CUR: begin
                            age_full = XW'(r_cursor) - XW'(1);
                            age_go   = (r_cursor != '0) && (age_full < XW'(held_cnt));
                        end
                        OP_READ_AGE: begin
                            age_full = XW'(i_item.entry_index);
                            age_go   = (age_full < XW'(held_cnt));
                        end
                        OP_CLEAR: begin
                            n_oldest   = '0;
                            n_next     = '0;
                            n_cursor   = '0;
                            n_ins_len  = '0;
                            n_differs  = 1'b0;
                            n_too_long = 1'b0;
                        end
                        default: begin
                            n_status = ST_FAIL;
                        end
                    endcase
                    if (i_item.operation == OP_READ_CUR ||
                        i_item.operation == OP_READ_AGE) begin
                        if (age_go) begin
                            n_slot     = age_slot(r_next, SW'(age_full));
                            n_k        = '0;
                            o_rd_en    = 1'b1;
                            o_rd_addr0 = addr_of(n_slot, '0);
                            o_rd_addr1 = addr_of(n_slot, idx_after('0));
                            n_state    = S_RD;
                        end else begin
                            n_status = ST_FAIL;
                        end
                    end
                end
            end
            S_INS: begin
                n_state = S_RESP;
                if (r_char != 8'd0) begin
                    if (r_ins_len == '0 && !r_too_long) begin
                        dif = (held_cnt == '0);
                    end
                    if (r_ins_len == MAX_LEN) begin
                        too_long = 1'b1;
                    end else begin
                        if (held_cnt != '0 && i_rd_data0 != r_char) begin
                            dif = 1'b1;
                        end
                        o_wr_en   = 1'b1;
                        o_wr_addr = addr_of(r_next, r_ins_len);
                        o_wr_data = r_char;
                        new_len   = r_ins_len + 1'b1;
                    end
                end
                if (!r_last) begin
                    n_ins_len  = new_len;
                    n_differs  = dif;
                    n_too_long = too_long;
                    n_status   = ST_OK;
                end else begin
                    // newest entry's character just past the new command
                    if (new_len == MAX_LEN) begin
                        tail_char = 8'd0;
                    end else if (new_len == r_ins_len) begin
                        tail_char = i_rd_data0;
                    end else begin
                        tail_char = i_rd_data1;
                    end
                    if (too_long) begin
                        n_status = ST_LONG;
                    end else if (new_len == '0) begin
                        n_status = ST_FAIL;
                    end else begin
                        if (held_cnt == '0 || tail_char != 8'd0) begin
                            dif = 1'b1;
                        end
                        if (!dif) begin
                            n_status = ST_DUP;
                        end else begin
                            n_status = ST_OK;
                            n_next   = slot_next(r_next);
                            if (held_cnt == LAST_SLOT) begin
                                n_oldest = slot_next(r_oldest);
                            end
                            // terminate the stored command unless it fills the slot
                            if (new_len != MAX_LEN) begin
                                n_term_addr = addr_of(r_next, new_len);
                                n_state     = S_TERM;
                            end
                        end
                    end
                    n_ins_len  = '0;
                    n_differs  = 1'b0;
                    n_too_long = 1'b0;
                end
            end
            S_TERM: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_term_addr;
                o_wr_data = 8'd0;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (i_space) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD: begin
                next_char = (r_k >= LEN_LIM) ? 8'd0 : i_rd_data1;
                if (i_space) begin
                    o_push = 1'b1;
                    if (i_rd_data0 == 8'd0) begin
                        o_push_item.status = ST_FAIL;
                        n_state            = S_IDLE;
                    end else begin
                        o_push_item.status      = ST_OK;
                        o_push_item.char_out    = i_rd_data0;
                        o_push_item.char_valid  = 1'b1;
                        o_push_item.last_result = (next_char == 8'd0);
                        if (next_char == 8'd0) begin
                            n_state = S_IDLE;
                        end else begin
                            // advance and fetch the following pair
                            n_k        = r_k + 1'b1;
                            o_rd_en    = 1'b1;
                            o_rd_addr0 = addr_of(r_slot, n_k);
                            o_rd_addr1 = addr_of(r_slot, idx_after(n_k));
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_oldest   <= '0;
            r_next     <= '0;
            r_cursor   <= '0;
            r_ins_len  <= '0;
            r_differs  <= 1'b0;
            r_too_long <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_next      <= n_next;
            r_cursor    <= n_cursor;
            r_ins_len   <= n_ins_len;
            r_differs   <= n_differs;
            r_too_long  <= n_too_long;
            r_char      <= n_char;
            r_last      <= n_last;
            r_slot      <= n_slot;
            r_k         <= n_k;
            r_status    <= n_status;
            r_term_addr <= n_term_addr;
        end
    end

    `CHR_ASSERT_IMP(a_cursor_in_range, i_clk, i_rst_n, 1'b1, r_cursor <= held_cnt)
    `CHR_ASSERT_IMP(a_long_at_limit, i_clk, i_rst_n, r_too_long, r_ins_len == MAX_LEN)
    `CHR_ASSERT_IMP(a_char_nonzero, i_clk, i_rst_n, o_push && o_push_item.char_valid, o_push_item.char_out != 8'd0)
    `CHR_ASSERT_NXT(a_busy_after_take, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `CHR_ASSERT_IMP(a_no_write_idle, i_clk, i_rst_n, r_state == S_IDLE, !o_wr_en)

endmodule

// ===== hw/rtl/command_history_ring.sv =====
// Command history ring: ENTRIES slots of ENTRY_CHARS characters in one two-read-port memory.
// Items are taken one at a time: the input stalls in every state but S_IDLE, until the
// result has entered the output queue. A read streams one character per memory read,
// and a full output queue holds the sequencer until it has space.
// Synchronous active-low reset empties the ring at once; the memory needs no clearing.
`timescale 1ns / 1ps

module command_history_ring #(
    parameter int ENTRIES     = chr_pkg::ENTRIES_DEFAULT,
    parameter int ENTRY_CHARS = chr_pkg::ENTRY_CHARS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  chr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output chr_pkg::t_out_item o_out_item
);

    import chr_pkg::*;

    localparam int AW = $clog2(ENTRIES * ENTRY_CHARS);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr0;
    logic [AW-1:0] rd_addr1;
    logic [7:0]    rd_data0;
    logic [7:0]    rd_data1;
    logic          push;
    t_out_item     push_item;
    logic          space;

    chr_mem #(
        .ENTRIES     (ENTRIES),
        .ENTRY_CHARS (ENTRY_CHARS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_en    (rd_en),
        .i_rd_addr0 (rd_addr0),
        .i_rd_addr1 (rd_addr1),
        .o_rd_data0 (rd_data0),
        .o_rd_data1 (rd_data1)
    );

    chr_ctrl #(
        .ENTRIES     (ENTRIES),
        .ENTRY_CHARS (ENTRY_CHARS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_item      (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_item (push_item),
        .i_space     (space),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr0  (rd_addr0),
        .o_rd_addr1  (rd_addr1),
        .i_rd_data0  (rd_data0),
        .i_rd_data1  (rd_data1)
    );

    chr_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
